[design/pgwh_pkg.sv]
// Shared types and constants for the partition gap weight histogram.
package pgwh_pkg;

   localparam int PART_WIDTH     = 16;
   localparam int WEIGHT_WIDTH   = 16;
   localparam int INDEX_WIDTH    = 8;
   localparam int LIMIT_WIDTH    = 8;
   localparam int COUNT_WIDTH    = 40;
   localparam int BIN_COUNT      = 256;
   localparam int BIN_ADDR_WIDTH = $clog2(BIN_COUNT);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // work item handed from the front end to the histogram side
   typedef struct packed {
      kind_type                kind;
      logic                    suitable;
      logic [WEIGHT_WIDTH-1:0] weight;
      logic [INDEX_WIDTH-1:0]  bin_index;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

[design/pgwh_front.sv]
// Front end: accepts transactions, tracks the gap check and weight of the open partition.
module pgwh_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [pgwh_pkg::PART_WIDTH-1:0]  req_part_value,
   input  logic [pgwh_pkg::INDEX_WIDTH-1:0] req_bin_index,
   input  pgwh_pkg::qstat_type              q_stat,
   output logic                             q_push,
   output pgwh_pkg::job_type                q_job
);
   import pgwh_pkg::*;

   localparam int DIV_SHIFT = PART_WIDTH + 1;
   // floor(2^17/3): quotient estimate is at most one short
   localparam logic [DIV_SHIFT-1:0] DIV3_MUL = DIV_SHIFT'((64'd1 << DIV_SHIFT) / 3);

   logic                             accept;
   logic [PART_WIDTH+DIV_SHIFT-1:0]  prod;
   logic [PART_WIDTH-1:0]            q_est;
   logic [PART_WIDTH+1:0]            r_est;
   logic [PART_WIDTH-1:0]            quot;
   logic                             mult3;

   logic                             s1_valid_ff, s1_valid_in;
   op_type                           s1_op_ff;
   logic [PART_WIDTH-1:0]            s1_part_ff;
   logic [INDEX_WIDTH-1:0]           s1_idx_ff;
   logic [PART_WIDTH-1:0]            s1_quot_ff;
   logic                             s1_mult3_ff;
   logic                             s1_is_job;
   logic                             s1_advance;

   logic [PART_WIDTH-1:0]            prev_ff, prev_in;
   logic                             prev_mult3_ff, prev_mult3_in;
   logic                             gap_ok_ff, gap_ok_in;
   logic [WEIGHT_WIDTH-1:0]          wsum_ff, wsum_in;

   logic [PART_WIDTH:0]              diff;
   logic [PART_WIDTH:0]              need;
   logic                             gap_pass;
   logic [WEIGHT_WIDTH:0]            wsum_add;

   // divide the incoming part by 3: reciprocal multiply, then one correction
   always_comb begin
      prod  = (PART_WIDTH+DIV_SHIFT)'(req_part_value) * (PART_WIDTH+DIV_SHIFT)'(DIV3_MUL);
      q_est = prod[PART_WIDTH+DIV_SHIFT-1:DIV_SHIFT];
      r_est = (PART_WIDTH+2)'(req_part_value) - (PART_WIDTH+2)'(q_est) * (PART_WIDTH+2)'(3);
      if (r_est >= (PART_WIDTH+2)'(3)) begin
         quot  = q_est + PART_WIDTH'(1);
         mult3 = (r_est == (PART_WIDTH+2)'(3));
      end else begin
         quot  = q_est;
         mult3 = (r_est == '0);
      end
   end

   assign s1_is_job  = (s1_op_ff == OP_READ) || (s1_part_ff == '0);
   assign s1_advance = s1_valid_ff && (!s1_is_job || !q_stat.full);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);

   assign q_push           = s1_advance && s1_is_job;
   assign q_job.kind       = (s1_op_ff == OP_READ) ? KIND_READ : KIND_REPORT;
   assign q_job.suitable   = (s1_op_ff == OP_PUSH) && gap_ok_ff;
   assign q_job.weight     = (s1_op_ff == OP_PUSH) ? wsum_ff : '0;
   assign q_job.bin_index  = s1_idx_ff;

   // partition state update
   always_comb begin
      diff     = {1'b0, prev_ff} - {1'b0, s1_part_ff};
      need     = prev_mult3_ff ? (PART_WIDTH+1)'(4) : (PART_WIDTH+1)'(3);
      gap_pass = !diff[PART_WIDTH] && (diff >= need);
      wsum_add = {1'b0, wsum_ff} + (WEIGHT_WIDTH+1)'(s1_quot_ff) + (WEIGHT_WIDTH+1)'(1);

      prev_in       = prev_ff;
      prev_mult3_in = prev_mult3_ff;
      gap_ok_in     = gap_ok_ff;
      wsum_in       = wsum_ff;
      if (s1_advance && (s1_op_ff == OP_PUSH)) begin
         if (s1_part_ff == '0) begin
            prev_in       = '0;
            prev_mult3_in = 1'b0;
            gap_ok_in     = 1'b1;
            wsum_in       = '0;
         end else begin
            prev_in       = s1_part_ff;
            prev_mult3_in = s1_mult3_ff;
            if ((prev_ff != '0) && !gap_pass) begin
               gap_ok_in = 1'b0;
            end
            wsum_in = wsum_add[WEIGHT_WIDTH] ? WEIGHT_MAX : wsum_add[WEIGHT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         prev_ff       <= '0;
         prev_mult3_ff <= 1'b0;
         gap_ok_ff     <= 1'b1;
         wsum_ff       <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         prev_ff       <= prev_in;
         prev_mult3_ff <= prev_mult3_in;
         gap_ok_ff     <= gap_ok_in;
         wsum_ff       <= wsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op_type'(req_op);
         s1_part_ff  <= req_part_value;
         s1_idx_ff   <= req_bin_index;
         s1_quot_ff  <= quot;
         s1_mult3_ff <= mult3;
      end
   end

endmodule

[design/pgwh_queue.sv]
// Short FIFO of jobs between the front end and the histogram side.
module pgwh_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pgwh_pkg::job_type   push_job,
   input  logic                pop,
   output pgwh_pkg::job_type   head_job,
   output pgwh_pkg::qstat_type stat
);
   import pgwh_pkg::*;

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign stat.full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head_job       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/pgwh_back.sv]
// Back end: histogram read-modify-write with forwarding, and the result register.
module pgwh_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pgwh_pkg::LIMIT_WIDTH-1:0]  weight_limit,
   input  pgwh_pkg::job_type                 head_job,
   input  pgwh_pkg::qstat_type               q_stat,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic                              rsp_suitable,
   output logic [pgwh_pkg::WEIGHT_WIDTH-1:0] rsp_weight,
   output logic                              rsp_over_limit,
   output logic [pgwh_pkg::COUNT_WIDTH-1:0]  rsp_bin_count
);
   import pgwh_pkg::*;

   logic [COUNT_WIDTH-1:0]    hist_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0]      bin_vld_ff;

   logic                      hd_incr;
   logic                      hd_over;
   logic                      hd_rd_ok;
   logic [BIN_ADDR_WIDTH-1:0] hd_addr;

   logic                      b2_valid_ff, b2_valid_in;
   logic                      b2_advance;
   kind_type                  b2_kind_ff;
   logic                      b2_suitable_ff;
   logic [WEIGHT_WIDTH-1:0]   b2_weight_ff;
   logic                      b2_over_ff;
   logic                      b2_incr_ff;
   logic                      b2_rd_ok_ff;
   logic [BIN_ADDR_WIDTH-1:0] b2_addr_ff;
   logic [COUNT_WIDTH-1:0]    rd_data_ff;
   logic                      rd_vld_ff;

   logic                      lw_valid_ff;
   logic [BIN_ADDR_WIDTH-1:0] lw_addr_ff;
   logic [COUNT_WIDTH-1:0]    lw_data_ff;

   logic [COUNT_WIDTH-1:0]    cur_count;
   logic [COUNT_WIDTH-1:0]    new_count;
   logic [COUNT_WIDTH-1:0]    res_count;
   logic                      wr_en;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_kind_ff;
   logic                      out_suitable_ff;
   logic [WEIGHT_WIDTH-1:0]   out_weight_ff;
   logic                      out_over_ff;
   logic [COUNT_WIDTH-1:0]    out_count_ff;

   // classify the job at the queue head
   always_comb begin
      hd_incr  = (head_job.kind == KIND_REPORT) && head_job.suitable &&
                 (head_job.weight <= WEIGHT_WIDTH'(weight_limit)) &&
                 (32'(head_job.weight) < BIN_COUNT);
      hd_over  = (head_job.kind == KIND_REPORT) && head_job.suitable && !hd_incr;
      hd_rd_ok = 32'(head_job.bin_index) < BIN_COUNT;
      hd_addr  = (head_job.kind == KIND_READ) ? BIN_ADDR_WIDTH'(head_job.bin_index)
                                              : head_job.weight[BIN_ADDR_WIDTH-1:0];
   end

   assign b2_advance  = b2_valid_ff && (!out_valid_ff || !rsp_stall);
   assign q_pop       = q_stat.not_empty && (!b2_valid_ff || b2_advance);
   assign b2_valid_in = q_pop || (b2_valid_ff && !b2_advance);

   // last write covers the case where the read raced a write to the same bin
   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == b2_addr_ff)) begin
         cur_count = lw_data_ff;
      end else if (rd_vld_ff) begin
         cur_count = rd_data_ff;
      end else begin
         cur_count = '0;
      end
      new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
      if (b2_kind_ff == KIND_READ) begin
         res_count = b2_rd_ok_ff ? cur_count : '0;
      end else begin
         res_count = b2_incr_ff ? new_count : '0;
      end
   end

   assign wr_en        = b2_advance && b2_incr_ff;
   assign out_valid_in = b2_advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[b2_addr_ff] <= new_count;
      end
      if (q_pop) begin
         rd_data_ff <= hist_mem[hd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff   <= '0;
         lw_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            bin_vld_ff[b2_addr_ff] <= 1'b1;
            lw_valid_ff            <= 1'b1;
         end
         b2_valid_ff  <= b2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b2_kind_ff     <= head_job.kind;
         b2_suitable_ff <= head_job.suitable;
         b2_weight_ff   <= head_job.weight;
         b2_over_ff     <= hd_over;
         b2_incr_ff     <= hd_incr;
         b2_rd_ok_ff    <= hd_rd_ok;
         b2_addr_ff     <= hd_addr;
         rd_vld_ff      <= bin_vld_ff[hd_addr];
      end
      if (wr_en) begin
         lw_addr_ff <= b2_addr_ff;
         lw_data_ff <= new_count;
      end
      if (b2_advance) begin
         out_kind_ff     <= b2_kind_ff;
         out_suitable_ff <= b2_suitable_ff;
         out_weight_ff   <= b2_weight_ff;
         out_over_ff     <= b2_over_ff;
         out_count_ff    <= res_count;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_suitable   = out_suitable_ff;
   assign rsp_weight     = out_weight_ff;
   assign rsp_over_limit = out_over_ff;
   assign rsp_bin_count  = out_count_ff;

endmodule

[design/partition_gap_weight_histogram.sv]
// Top level: partition gap check and weight histogram.
// Results pass the s1 stage, the job queue, the b2 stage and the result register.
// Throughput: one transaction per cycle while not stalled; a bin is read when its job
// leaves the queue, written as it leaves b2; the last write is forwarded to the next read.
// Reset (synchronous): partition state cleared, weight_limit = 255, all bin valid bits
// cleared in the same cycle, so the histogram reads zero with no clearing pass.
module partition_gap_weight_histogram (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [pgwh_pkg::PART_WIDTH-1:0]   req_part_value,
   input  logic [pgwh_pkg::INDEX_WIDTH-1:0]  req_bin_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic                              rsp_suitable,
   output logic [pgwh_pkg::WEIGHT_WIDTH-1:0] rsp_weight,
   output logic                              rsp_over_limit,
   output logic [pgwh_pkg::COUNT_WIDTH-1:0]  rsp_bin_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pgwh_pkg::LIMIT_WIDTH-1:0]  csr_weight_limit
);
   import pgwh_pkg::*;

   logic [LIMIT_WIDTH-1:0] weight_limit_ff;
   qstat_type              q_stat;
   logic                   q_push;
   logic                   q_pop;
   job_type                push_job;
   job_type                head_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_limit_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         weight_limit_ff <= csr_weight_limit;
      end
   end

   pgwh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_part_value (req_part_value),
      .req_bin_index  (req_bin_index),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   pgwh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   pgwh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .weight_limit   (weight_limit_ff),
      .head_job       (head_job),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_suitable   (rsp_suitable),
      .rsp_weight     (rsp_weight),
      .rsp_over_limit (rsp_over_limit),
      .rsp_bin_count  (rsp_bin_count)
   );

   a_no_queue_overflow : assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full && !q_pop))
      else $error("job pushed into a full queue");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.not_empty)
      else $error("job popped from an empty queue");

   a_read_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_READ)) |->
         (!rsp_suitable && !rsp_over_limit && (rsp_weight == '0)))
      else $error("read result carries partition fields");

   a_uncounted_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_REPORT) && (rsp_over_limit || !rsp_suitable)) |->
         (rsp_bin_count == '0))
      else $error("uncounted partition reports a nonzero bin count");

   a_over_needs_suitable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_over_limit) |-> rsp_suitable)
      else $error("over_limit set on an unsuitable partition");

endmodule

[sim/partition_gap_weight_histogram_test.sv]
// Self-checking testbench for the partition gap weight histogram block.
module partition_gap_weight_histogram_test;
   import pgwh_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 400_000;

   typedef struct packed {
      kind_type                kind;
      logic                    suitable;
      logic [WEIGHT_WIDTH-1:0] weight;
      logic                    over_limit;
      logic [COUNT_WIDTH-1:0]  bin_count;
   } report_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_op;
   logic [PART_WIDTH-1:0]   req_part_value;
   logic [INDEX_WIDTH-1:0]  req_bin_index;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_kind;
   logic                    rsp_suitable;
   logic [WEIGHT_WIDTH-1:0] rsp_weight;
   logic                    rsp_over_limit;
   logic [COUNT_WIDTH-1:0]  rsp_bin_count;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [LIMIT_WIDTH-1:0]  csr_weight_limit;

   // shadow of the block's state
   logic [PART_WIDTH-1:0]   last_part;
   logic                    gap_held;
   int unsigned             weight_acc;
   logic [COUNT_WIDTH-1:0]  bin_shadow [BIN_COUNT];
   logic [LIMIT_WIDTH-1:0]  limit_shadow;

   report_type pending_reports [$];
   report_type oldest;

   int error_count;
   int items_sent;
   int send_idle_pct;
   int stall_pct;
   int reads_seen;
   int counted_seen;
   int over_seen;
   int rejected_seen;

   partition_gap_weight_histogram i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_part_value   (req_part_value),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_suitable     (rsp_suitable),
      .rsp_weight       (rsp_weight),
      .rsp_over_limit   (rsp_over_limit),
      .rsp_bin_count    (rsp_bin_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_weight_limit (csr_weight_limit)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("Timeout with %0d results outstanding", pending_reports.size());
      $display("Verification failed");
      $finish;
   end

   // appends one expected result at the tail of the scoreboard
   function automatic void queue_report(report_type r);
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   // Works out the report, if any, that one accepted transaction causes.
   task automatic compute_report(op_type op, logic [PART_WIDTH-1:0] part,
                                 logic [INDEX_WIDTH-1:0] idx);
      report_type                r;
      int unsigned               need;
      logic [BIN_ADDR_WIDTH-1:0] slot;
      r = '0;
      if (op == OP_READ) begin
         r.kind      = KIND_READ;
         r.bin_count = bin_shadow[idx];
         queue_report(r);
      end else if (part == '0) begin
         r.kind     = KIND_REPORT;
         r.suitable = gap_held;
         r.weight   = weight_acc[WEIGHT_WIDTH-1:0];
         if (gap_held) begin
            if (weight_acc > limit_shadow || weight_acc >= BIN_COUNT) begin
               r.over_limit = 1'b1;
            end else begin
               slot = weight_acc[BIN_ADDR_WIDTH-1:0];
               if (bin_shadow[slot] != COUNT_MAX)
                  bin_shadow[slot] = bin_shadow[slot] + COUNT_WIDTH'(1);
               r.bin_count = bin_shadow[slot];
            end
         end
         queue_report(r);
         last_part  = '0;
         gap_held   = 1'b1;
         weight_acc = 0;
      end else begin
         if (last_part != '0) begin
            // larger part that is a multiple of 3 needs a gap of 4
            need = (last_part % 3 == 0) ? 4 : 3;
            if (!(last_part >= part && last_part - part >= need))
               gap_held = 1'b0;
         end
         last_part  = part;
         weight_acc = weight_acc + (int'(part) + 3) / 3;
         if (weight_acc > WEIGHT_MAX)
            weight_acc = 32'(WEIGHT_MAX);
      end
   endtask

   function automatic void check_field(string name, logic [COUNT_WIDTH-1:0] want,
                                       logic [COUNT_WIDTH-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // result side: check each accepted result, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual kind %0h count %0h",
                     $time, rsp_kind, rsp_bin_count);
         end else begin
            oldest = pending_reports.pop_front();
            check_field("kind", COUNT_WIDTH'(oldest.kind), COUNT_WIDTH'(rsp_kind));
            check_field("suitable", COUNT_WIDTH'(oldest.suitable), COUNT_WIDTH'(rsp_suitable));
            check_field("weight", COUNT_WIDTH'(oldest.weight), COUNT_WIDTH'(rsp_weight));
            check_field("over_limit", COUNT_WIDTH'(oldest.over_limit),
                        COUNT_WIDTH'(rsp_over_limit));
            check_field("bin_count", oldest.bin_count, rsp_bin_count);
            if (oldest.kind == KIND_READ)
               reads_seen++;
            else if (!oldest.suitable)
               rejected_seen++;
            else if (oldest.over_limit)
               over_seen++;
            else
               counted_seen++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Called at a clock edge; returns at the edge after acceptance or after an idle gap.
   task automatic send_item(op_type op, logic [PART_WIDTH-1:0] part,
                            logic [INDEX_WIDTH-1:0] idx);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_part_value <= part;
      req_bin_index  <= idx;
      do @(posedge clock); while (req_stall);
      compute_report(op, part, idx);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // a trailing part produces no result but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_WIDTH-1:0] value);
      settle_results();
      csr_valid        <= 1'b1;
      csr_weight_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      limit_shadow = value;
   endtask

   function automatic logic [INDEX_WIDTH-1:0] pick_bin();
      return ($urandom_range(3) == 0) ? INDEX_WIDTH'($urandom)
                                      : INDEX_WIDTH'($urandom_range(0, 40));
   endfunction

   // Builds a descending partition that meets the gap rule, optionally spoiling one gap.
   task automatic send_partition(bit spoil, bit wide);
      logic [PART_WIDTH-1:0] parts [$];
      int unsigned           p;
      int unsigned           gap;
      int                    n;
      int                    k;
      n = $urandom_range(0, 5);
      p = wide ? $urandom_range(1, 3000) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         parts.push_front(PART_WIDTH'(p));
         gap = 3 + $urandom_range(0, wide ? 2000 : 4);
         if (gap == 3 && (p + gap) % 3 == 0)
            gap = 4;
         p = p + gap;
      end
      if (spoil && parts.size() >= 2) begin
         k = $urandom_range(1, parts.size() - 1);
         case ($urandom_range(2))
            0: parts[k] = PART_WIDTH'(parts[k-1] + $urandom_range(0, 3));
            1: parts[k] = PART_WIDTH'(parts[k-1] - $urandom_range(1, 2));
            default: parts[k] = PART_WIDTH'(parts[k-1] - 3);
         endcase
      end
      foreach (parts[i]) begin
         send_item(OP_PUSH, parts[i], INDEX_WIDTH'($urandom));
         if ($urandom_range(15) == 0)
            send_item(OP_READ, PART_WIDTH'($urandom), pick_bin());
      end
      send_item(OP_PUSH, '0, INDEX_WIDTH'($urandom));
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
   endtask

   task automatic test_directed();
      send_item(OP_READ, '0, 8'd255);                // cleared at reset
      send_item(OP_PUSH, '0, 8'd0);                  // empty partition lands in bin 0
      send_item(OP_READ, 16'hffff, 8'd0);
      send_item(OP_PUSH, 16'd10, 8'd0);              // gaps of exactly 3, weight 10
      send_item(OP_PUSH, 16'd7, 8'd0);
      send_item(OP_PUSH, 16'd4, 8'd0);
      send_item(OP_PUSH, 16'd1, 8'd0);
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_PUSH, 16'd6, 8'd0);               // multiple of 3 with gap 3 fails
      send_item(OP_PUSH, 16'd3, 8'd0);
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_PUSH, 16'd5, 8'd0);               // ascending parts fail
      send_item(OP_PUSH, 16'd9, 8'd0);
      send_item(OP_READ, '0, 8'd10);                 // read leaves partition untouched
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_PUSH, 16'hffff, 8'hff);           // weight saturates
      send_item(OP_PUSH, 16'hffff, 8'hff);
      send_item(OP_PUSH, 16'hffff, 8'hff);
      send_item(OP_PUSH, '0, 8'hff);
      send_item(OP_PUSH, 16'hffff, 8'd0);            // suitable but no bin
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_READ, '0, 8'd10);
      settle_results();
   endtask

   task automatic test_limit_extremes();
      write_limit(8'd0);
      send_item(OP_PUSH, '0, 8'd0);                  // weight 0 still has a bin
      send_item(OP_PUSH, 16'd1, 8'd0);               // weight 1 over the limit
      send_item(OP_PUSH, '0, 8'd0);
      write_limit(8'd1);
      send_item(OP_PUSH, 16'd1, 8'd0);
      send_item(OP_PUSH, '0, 8'd0);
      write_limit(8'd255);
      send_item(OP_PUSH, 16'd764, 8'd0);             // weight 255, top bin
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_PUSH, 16'd765, 8'd0);             // weight 256, past the last bin
      send_item(OP_PUSH, '0, 8'd0);
      send_item(OP_READ, '0, 8'd255);
      send_item(OP_READ, '0, 8'd1);
      settle_results();
   endtask

   // 40-bit bin saturation cannot be reached in a simulation of this length.
   task automatic test_random_traffic(int count);
      int first;
      int choice;
      first = items_sent;
      while (items_sent - first < count) begin
         choice = $urandom_range(99);
         if (choice < 60)
            send_partition(1'b0, $urandom_range(9) == 0);
         else if (choice < 75)
            send_partition(1'b1, $urandom_range(9) == 0);
         else if (choice < 90)
            send_item(OP_READ, PART_WIDTH'($urandom), pick_bin());
         else
            send_item(OP_PUSH, PART_WIDTH'($urandom), INDEX_WIDTH'($urandom));
         if ($urandom_range(199) == 0)
            settle_results();
      end
      settle_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_PUSH;
      req_part_value   = '0;
      req_bin_index    = '0;
      csr_valid        = 1'b0;
      csr_weight_limit = '0;
      last_part        = '0;
      gap_held         = 1'b1;
      weight_acc       = 0;
      limit_shadow     = 8'd255;
      foreach (bin_shadow[i]) bin_shadow[i] = '0;
      error_count      = 0;
      items_sent       = 0;
      set_idling(0, 0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_limit_extremes();

      set_idling(0, 0);
      test_random_traffic(225);
      write_limit(8'd20);
      set_idling(67, 0);
      test_random_traffic(225);
      write_limit(LIMIT_WIDTH'($urandom_range(1, 254)));
      set_idling(0, 67);
      test_random_traffic(225);
      write_limit(8'd255);
      set_idling(25, 25);
      test_random_traffic(225);

      $display("Sent %0d transactions under four idle/stall mixes and five weight limits",
               items_sent);
      $display("Reports: %0d binned, %0d over limit, %0d gap failures; %0d bin reads",
               counted_seen, over_seen, rejected_seen, reads_seen);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
